@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files of the jack leveling block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/jls_pkg.sv @@
// Package for the jack leveling step block: word types, codes, defaults and
// the level / link scoring helpers. No dependencies.
package jls_pkg;

  localparam int MAX_JACKS_DEF = 8;
  localparam int MAX_LINKS_DEF = 4;

  localparam logic [3:0]  JACK_COUNT_RST = 4'd8;
  localparam logic [14:0] PRECISION_RST  = 15'd128;

  // configuration register indexes
  localparam logic [1:0] CFG_JACK_COUNT = 2'd0;
  localparam logic [1:0] CFG_PRECISION  = 2'd1;

  // commands
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;

  // axis / direction codes
  localparam logic [1:0] CODE_X0  = 2'd0;
  localparam logic [1:0] CODE_X1  = 2'd1;
  localparam logic [1:0] CODE_Y10 = 2'd2;
  localparam logic [1:0] CODE_Y11 = 2'd3;

  // actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RAISE = 2'd1;
  localparam logic [1:0] ACT_LOWER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_SCORE,
    ST_ACT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         jack;
    logic [1:0]         slot;
    logic [2:0]         neighbor;
    logic [1:0]         axis_code;
    logic               link_valid;
    logic signed [15:0] x_angle;
    logic signed [15:0] y_angle;
  } in_word_t;

  typedef struct packed {
    logic [2:0] target_jack;
    logic [1:0] action;
    logic       was_level;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       present;
    logic [1:0] code;
    logic [2:0] neighbor;
  } link_entry_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } tilt_t;

  // 2*(|x|+|y|) > 5*prec
  function automatic logic level_exceeds(input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         input logic [14:0] prec);
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [17:0] sum;
    logic [18:0] lhs;
    logic [18:0] rhs;
    xs  = 17'(x);
    ys  = 17'(y);
    ax  = xs[16] ? 17'(-xs) : 17'(xs);
    ay  = ys[16] ? 17'(-ys) : 17'(ys);
    sum = 18'(ax) + 18'(ay);
    lhs = {sum, 1'b0};
    rhs = 19'({prec, 2'b00}) + 19'(prec);
    return lhs > rhs;
  endfunction

  // +1 / -1 / 0 contribution of one present link; equality counts as no change
  function automatic logic signed [1:0] link_score(input logic [1:0] code,
                                                   input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   input logic [14:0] prec);
    logic signed [15:0] p;
    logic alt;
    logic agt;
    logic blt;
    logic bgt;
    logic signed [1:0] res;
    p   = signed'({1'b0, prec});
    alt = a < p;
    agt = a > p;
    blt = b < p;
    bgt = b > p;
    if ((alt && code == CODE_X1) || (agt && code == CODE_X0)) begin
      res = 2'sd1;
    end else if ((alt && code == CODE_X0) || (agt && code == CODE_X1)) begin
      res = -2'sd1;
    end else if ((blt && code == CODE_Y11) || (bgt && code == CODE_Y10)) begin
      res = 2'sd1;
    end else if ((blt && code == CODE_Y10) || (bgt && code == CODE_Y11)) begin
      res = -2'sd1;
    end else begin
      res = 2'sd0;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/jls_link_mem.sv @@
// Adjacency store: neighbor/code memory with registered read, plus per-entry
// present bits cleared at reset. Depends on jls_pkg.
module jls_link_mem #(
  parameter int DEPTH = jls_pkg::MAX_JACKS_DEF * jls_pkg::MAX_LINKS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  jls_pkg::link_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output jls_pkg::link_entry_t rd_data
);

  logic [4:0]       mem_r [DEPTH];
  logic [DEPTH-1:0] present_r;
  logic [4:0]       rd_q_r;
  logic             present_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_data.code, wr_data.neighbor};
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      present_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        present_r[wr_addr] <= wr_data.present;
      end
      if (rd_en) begin
        present_q_r <= present_r[rd_addr];
      end
    end
  end

  // an entry never written reads as an empty slot
  always_comb begin
    rd_data = '0;
    if (present_q_r) begin
      rd_data.present  = 1'b1;
      rd_data.code     = rd_q_r[4:3];
      rd_data.neighbor = rd_q_r[2:0];
    end
  end

endmodule

@@ rtl/core/jls_tilt_mem.sv @@
// Tilt sample store: one x/y word per jack, registered read, per-entry valid
// bits so that an unwritten jack reads as zero tilt. Depends on jls_pkg.
module jls_tilt_mem #(
  parameter int DEPTH = jls_pkg::MAX_JACKS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  jls_pkg::tilt_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output jls_pkg::tilt_t rd_data
);

  jls_pkg::tilt_t   mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  jls_pkg::tilt_t   rd_q_r;
  logic             valid_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      valid_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = valid_q_r ? rd_q_r : '0;

endmodule

@@ rtl/core/jack_leveling_step_top.sv @@
// Top level of the jack leveling step block: command decode, step sequencer,
// score pipeline and result register. Uses jls_pkg, jls_link_mem, jls_tilt_mem.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------------
//   input   | start, busy, in_word                    | word taken when start & !busy
//   result  | out_valid, out_word                     | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid & ready
//
// Write and sample commands leave busy low.
// The single link memory read port paces the scoring walk, one slot per cycle
// through a three-deep read pipeline.
// Reset (rst_n low, synchronous) clears the adjacency present bits, tilt valid
// bits, control registers and phase; payload and score registers are not reset.
// Results cannot be stalled; config is taken only while idle.
`include "assert_macros.svh"

module jack_leveling_step_top #(
  parameter int MAX_JACKS = jls_pkg::MAX_JACKS_DEF,
  parameter int MAX_LINKS = jls_pkg::MAX_LINKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  jls_pkg::in_word_t  in_word,
  output logic               out_valid,
  output jls_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // jack and slot fields are 3 and 2 bits wide, so only that much is reachable
  localparam int NJ  = (MAX_JACKS < 8) ? MAX_JACKS : 8;
  localparam int NL  = (MAX_LINKS < 4) ? MAX_LINKS : 4;
  localparam int TAW = $clog2(NJ);
  localparam int LD  = NJ * NL;
  localparam int LAW = $clog2(LD);
  localparam int SW  = (NL > 1) ? $clog2(NL) : 1;
  localparam int SCW = $clog2(NL + 1) + 2;
  localparam logic [3:0]    NJ4       = 4'(NJ);
  localparam logic [SW-1:0] SLOT_LAST = SW'(NL - 1);

  jls_pkg::state_t state_r, state_nxt;

  logic [3:0]  jack_count_r;
  logic [14:0] precision_r;
  logic [3:0]  scan_n;
  logic        phase_r, phase_nxt;

  // level check
  logic [3:0] lv_cnt_r, lv_cnt_nxt;
  logic       lv_issue;
  logic       lv_pend_r;
  logic       unlevel_r, unlevel_nxt;

  // score walk, stage A issues link read, B issues tilt read, C accumulates
  logic [3:0]    sc_jack_r, sc_jack_nxt;
  logic [SW-1:0] sc_slot_r, sc_slot_nxt;
  logic          sc_issue;
  logic           a_vld_r;
  logic [TAW-1:0] a_jack_r;
  logic           a_last_r;
  logic           b_vld_r;
  logic           b_use_r;
  logic [1:0]     b_code_r;
  logic [TAW-1:0] b_jack_r;
  logic           b_last_r;
  logic signed [SCW-1:0] run_r;
  logic [SCW-1:0]        best_r;
  logic signed [SCW-1:0] score_r [NJ];
  logic signed [1:0]     contrib;
  logic signed [SCW-1:0] acc;
  logic [SCW-1:0]        acc_abs;
  logic                  step_go;

  // action scan
  logic [3:0]            act_j_r, act_j_nxt;
  logic signed [SCW-1:0] act_s;
  logic [SCW-1:0]        act_abs;
  logic                  act_hit;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [2:0]            pend_jack_r, pend_jack_nxt;
  logic [1:0]            pend_act_r, pend_act_nxt;

  logic               out_valid_r, out_valid_nxt;
  jls_pkg::out_word_t out_word_r, out_word_nxt;

  // memory ports
  logic                 link_wr_en;
  logic [LAW-1:0]       link_wr_addr;
  jls_pkg::link_entry_t link_wr_data;
  logic                 link_rd_en;
  logic [LAW-1:0]       link_rd_addr;
  jls_pkg::link_entry_t link_rd_data;
  logic                 tilt_wr_en;
  logic [TAW-1:0]       tilt_wr_addr;
  jls_pkg::tilt_t       tilt_wr_data;
  logic                 tilt_rd_en;
  logic [TAW-1:0]       tilt_rd_addr;
  jls_pkg::tilt_t       tilt_rd_data;

  jls_link_mem #(.DEPTH(LD), .AW(LAW)) u_link_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

  jls_tilt_mem #(.DEPTH(NJ), .AW(TAW)) u_tilt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tilt_wr_en),
    .wr_addr (tilt_wr_addr),
    .wr_data (tilt_wr_data),
    .rd_en   (tilt_rd_en),
    .rd_addr (tilt_rd_addr),
    .rd_data (tilt_rd_data)
  );

  assign busy      = (state_r != jls_pkg::ST_IDLE);
  assign cfg_ready = (state_r == jls_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign scan_n    = (jack_count_r > NJ4) ? NJ4 : jack_count_r;

  assign link_wr_addr = LAW'(int'(in_word.jack[TAW-1:0]) * NL + int'(in_word.slot));
  assign link_wr_data = '{present: in_word.link_valid, code: in_word.axis_code,
                          neighbor: in_word.neighbor};
  assign tilt_wr_addr = in_word.jack[TAW-1:0];
  assign tilt_wr_data = '{x: in_word.x_angle, y: in_word.y_angle};
  assign link_rd_addr = LAW'(int'(sc_jack_r[TAW-1:0]) * NL + int'(sc_slot_r));

  // stage C arithmetic
  always_comb begin
    contrib = b_use_r ? jls_pkg::link_score(b_code_r, tilt_rd_data.x, tilt_rd_data.y,
                                            precision_r) : 2'sd0;
    acc     = run_r + SCW'(contrib);
    acc_abs = acc[SCW-1] ? SCW'(-acc) : SCW'(acc);
  end

  // action test for the jack under the scan pointer
  always_comb begin
    act_s   = score_r[act_j_r[TAW-1:0]];
    act_abs = act_s[SCW-1] ? SCW'(-act_s) : SCW'(act_s);
    act_hit = (best_r != '0) && (act_abs == best_r) &&
              ((act_s[SCW-1] && !phase_r) ||
               (!act_s[SCW-1] && (act_s != '0) && phase_r));
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    lv_cnt_nxt    = lv_cnt_r;
    lv_issue      = 1'b0;
    unlevel_nxt   = unlevel_r |
                    (lv_pend_r && jls_pkg::level_exceeds(tilt_rd_data.x, tilt_rd_data.y,
                                                         precision_r));
    sc_jack_nxt   = sc_jack_r;
    sc_slot_nxt   = sc_slot_r;
    sc_issue      = 1'b0;
    step_go       = 1'b0;
    act_j_nxt     = act_j_r;
    pend_vld_nxt  = pend_vld_r;
    pend_jack_nxt = pend_jack_r;
    pend_act_nxt  = pend_act_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    link_wr_en    = 1'b0;
    link_rd_en    = 1'b0;
    tilt_wr_en    = 1'b0;
    tilt_rd_en    = 1'b0;
    tilt_rd_addr  = '0;

    unique case (state_r)
      jls_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_word.cmd)
            jls_pkg::CMD_WRITE: begin
              link_wr_en = ({1'b0, in_word.jack} < NJ4) && (int'(in_word.slot) < NL);
            end
            jls_pkg::CMD_SAMPLE: begin
              tilt_wr_en = ({1'b0, in_word.jack} < NJ4);
            end
            jls_pkg::CMD_STEP: begin
              state_nxt   = jls_pkg::ST_LEVEL;
              lv_cnt_nxt  = '0;
              unlevel_nxt = 1'b0;
              step_go     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      jls_pkg::ST_LEVEL: begin
        if (lv_cnt_r < scan_n) begin
          tilt_rd_en   = 1'b1;
          tilt_rd_addr = lv_cnt_r[TAW-1:0];
          lv_issue     = 1'b1;
          lv_cnt_nxt   = lv_cnt_r + 4'd1;
        end else if (!lv_pend_r) begin
          if (unlevel_r) begin
            state_nxt   = jls_pkg::ST_SCORE;
            sc_jack_nxt = '0;
            sc_slot_nxt = '0;
          end else begin
            out_valid_nxt            = 1'b1;
            out_word_nxt.target_jack = '0;
            out_word_nxt.action      = jls_pkg::ACT_NONE;
            out_word_nxt.was_level   = 1'b1;
            out_word_nxt.last        = 1'b1;
            state_nxt                = jls_pkg::ST_IDLE;
          end
        end
      end

      jls_pkg::ST_SCORE: begin
        // stage B: neighbor tilt read
        tilt_rd_en   = a_vld_r;
        tilt_rd_addr = link_rd_data.neighbor[TAW-1:0];
        if (sc_jack_r < scan_n) begin
          link_rd_en = 1'b1;
          sc_issue   = 1'b1;
          if (sc_slot_r == SLOT_LAST) begin
            sc_slot_nxt = '0;
            sc_jack_nxt = sc_jack_r + 4'd1;
          end else begin
            sc_slot_nxt = sc_slot_r + SW'(1);
          end
        end else if (!a_vld_r && !b_vld_r) begin
          state_nxt    = jls_pkg::ST_ACT;
          act_j_nxt    = '0;
          pend_vld_nxt = 1'b0;
        end
      end

      jls_pkg::ST_ACT: begin
        // one result held back so the final one can carry last
        if (act_j_r < scan_n) begin
          act_j_nxt = act_j_r + 4'd1;
          if (act_hit) begin
            if (pend_vld_r) begin
              out_valid_nxt            = 1'b1;
              out_word_nxt.target_jack = pend_jack_r;
              out_word_nxt.action      = pend_act_r;
              out_word_nxt.was_level   = 1'b0;
              out_word_nxt.last        = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_jack_nxt = act_j_r[2:0];
            pend_act_nxt  = phase_r ? jls_pkg::ACT_LOWER : jls_pkg::ACT_RAISE;
          end
        end else begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.target_jack = pend_vld_r ? pend_jack_r : 3'd0;
          out_word_nxt.action      = pend_vld_r ? pend_act_r : jls_pkg::ACT_NONE;
          out_word_nxt.was_level   = 1'b0;
          out_word_nxt.last        = 1'b1;
          pend_vld_nxt             = 1'b0;
          phase_nxt                = ~phase_r;
          state_nxt                = jls_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = jls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jls_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jack_count_r <= jls_pkg::JACK_COUNT_RST;
      precision_r  <= jls_pkg::PRECISION_RST;
      phase_r      <= 1'b0;
      lv_cnt_r     <= '0;
      lv_pend_r    <= 1'b0;
      unlevel_r    <= 1'b0;
      sc_jack_r    <= '0;
      sc_slot_r    <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      act_j_r      <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          jls_pkg::CFG_JACK_COUNT: jack_count_r <= cfg_data[3:0];
          jls_pkg::CFG_PRECISION:  precision_r  <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      lv_cnt_r    <= lv_cnt_nxt;
      lv_pend_r   <= lv_issue;
      unlevel_r   <= unlevel_nxt;
      sc_jack_r   <= sc_jack_nxt;
      sc_slot_r   <= sc_slot_nxt;
      a_vld_r     <= sc_issue;
      b_vld_r     <= a_vld_r;
      act_j_r     <= act_j_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and score registers
  always_ff @(posedge clk) begin
    pend_jack_r <= pend_jack_nxt;
    pend_act_r  <= pend_act_nxt;
    out_word_r  <= out_word_nxt;
    a_jack_r    <= sc_jack_r[TAW-1:0];
    a_last_r    <= (sc_slot_r == SLOT_LAST);
    b_use_r     <= link_rd_data.present && ({1'b0, link_rd_data.neighbor} < NJ4);
    b_code_r    <= link_rd_data.code;
    b_jack_r    <= a_jack_r;
    b_last_r    <= a_last_r;
    if (step_go) begin
      run_r  <= '0;
      best_r <= '0;
    end else if (b_vld_r) begin
      if (b_last_r) begin
        score_r[b_jack_r] <= acc;
        run_r             <= '0;
        if (acc_abs > best_r) begin
          best_r <= acc_abs;
        end
      end else begin
        run_r <= acc;
      end
    end
  end

  `AST_NOW(a_last_idle, clk, rst_n, out_valid && out_word.last,
           state_r == jls_pkg::ST_IDLE, "final word not aligned with return to idle")
  `AST_NOW(a_mid_act, clk, rst_n, out_valid && !out_word.last,
           state_r == jls_pkg::ST_ACT, "non-final word outside action scan")
  `AST_NOW(a_level_word, clk, rst_n, out_valid && out_word.was_level,
           out_word.action == jls_pkg::ACT_NONE && out_word.last,
           "level word carries an action or is not final")
  `AST_NEXT(a_step_busy, clk, rst_n, start && !busy && in_word.cmd == jls_pkg::CMD_STEP,
            busy, "step accepted but block not busy")
  `AST_NOW(a_pipe_score, clk, rst_n, a_vld_r || b_vld_r,
           state_r == jls_pkg::ST_SCORE, "score pipeline active outside scoring")

endmodule

@@ test/jack_leveling_step_top_tb.sv @@
// Testbench for jack_leveling_step_top: directed and random command words, config
// changes between phases, step results checked against an in-bench leveling model.
// Depends on jls_pkg and the jack_leveling_step_top RTL.
`timescale 1ns / 100ps

module jack_leveling_step_top_tb;
  import jls_pkg::*;

  localparam int JACKS       = MAX_JACKS_DEF;
  localparam int LINKS       = MAX_LINKS_DEF;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 13;
  localparam int N_PHASES    = 7;

  localparam logic [1:0] CMD_NOP   = 2'd3;  // undefined command, dropped by the block
  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index

  // Tracks link table, tilts, phase and registers; predicts the words of each step.
  class leveling_board;
    link_entry_t links [JACKS*LINKS];
    tilt_t       tilts [JACKS];
    logic        lower_phase;
    logic [3:0]  jack_count;
    logic [14:0] precision;
    out_word_t   pending_actions [$];
    int          errors;

    function new();
      foreach (links[i]) links[i] = '0;
      foreach (tilts[i]) tilts[i] = '0;
      lower_phase = 1'b0;
      jack_count  = JACK_COUNT_RST;
      precision   = PRECISION_RST;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == CFG_JACK_COUNT) jack_count = data[3:0];
      else if (idx == CFG_PRECISION) precision = data[14:0];
    endfunction

    // appends one expected word at the tail of the queue
    function void add_word(out_word_t r);
      pending_actions = {pending_actions, r};
    endfunction

    // +1 / -1 / 0 vote of one link; equality with precision never votes
    function int link_vote(int idx);
      int a;
      int b;
      int p;
      logic [1:0] code;
      a    = $signed(tilts[links[idx].neighbor].x);
      b    = $signed(tilts[links[idx].neighbor].y);
      p    = int'(precision);
      code = links[idx].code;
      if ((a < p && code == CODE_X1) || (a > p && code == CODE_X0)) return 1;
      if ((a < p && code == CODE_X0) || (a > p && code == CODE_X1)) return -1;
      if ((b < p && code == CODE_Y11) || (b > p && code == CODE_Y10)) return 1;
      if ((b < p && code == CODE_Y10) || (b > p && code == CODE_Y11)) return -1;
      return 0;
    endfunction

    function void plan_step();
      int n;
      int xv;
      int yv;
      int sum;
      int best;
      int mag;
      int k;
      int score [JACKS];
      bit unlevel;
      out_word_t r;
      n       = (jack_count > JACKS) ? JACKS : int'(jack_count);
      unlevel = 1'b0;
      for (int j = 0; j < n; j++) begin
        xv  = $signed(tilts[j].x);
        yv  = $signed(tilts[j].y);
        sum = ((xv < 0) ? -xv : xv) + ((yv < 0) ? -yv : yv);
        if (2 * sum > 5 * int'(precision)) unlevel = 1'b1;
      end
      r = '0;
      if (!unlevel) begin
        r.action    = ACT_NONE;
        r.was_level = 1'b1;
        r.last      = 1'b1;
        add_word(r);
        return;
      end
      best = 0;
      for (int j = 0; j < n; j++) begin
        score[j] = 0;
        for (int s = 0; s < LINKS; s++) begin
          if (links[j*LINKS + s].present) score[j] += link_vote(j*LINKS + s);
        end
        mag = (score[j] < 0) ? -score[j] : score[j];
        if (mag > best) best = mag;
      end
      k = 0;
      for (int j = 0; j < n; j++) begin
        mag = (score[j] < 0) ? -score[j] : score[j];
        if (best != 0 && mag == best) begin
          r.target_jack = 3'(j);
          if (score[j] < 0 && !lower_phase) begin
            r.action = ACT_RAISE;
            add_word(r);
            k++;
          end else if (score[j] > 0 && lower_phase) begin
            r.action = ACT_LOWER;
            add_word(r);
            k++;
          end
        end
      end
      lower_phase = ~lower_phase;
      if (k == 0) begin
        r        = '0;
        r.action = ACT_NONE;
        r.last   = 1'b1;
        add_word(r);
      end else begin
        pending_actions[pending_actions.size()-1].last = 1'b1;
      end
    endfunction

    function void take_command(in_word_t w);
      case (w.cmd)
        CMD_WRITE: begin
          links[int'(w.jack)*LINKS + int'(w.slot)].present  = w.link_valid;
          links[int'(w.jack)*LINKS + int'(w.slot)].code     = w.axis_code;
          links[int'(w.jack)*LINKS + int'(w.slot)].neighbor = w.neighbor;
        end
        CMD_SAMPLE: begin
          tilts[w.jack].x = w.x_angle;
          tilts[w.jack].y = w.y_angle;
        end
        CMD_STEP: plan_step();
        default: ;
      endcase
    endfunction

    function void check_action(out_word_t got);
      out_word_t want;
      if (pending_actions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: jack %0d act %0d level %0d last %0d",
                   got.target_jack, got.action, got.was_level, got.last);
        return;
      end
      want = pending_actions.pop_front();
      if (got.target_jack !== want.target_jack || got.action !== want.action ||
          got.was_level !== want.was_level || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: want jack %0d act %0d level %0d last %0d, got %0d %0d %0d %0d",
                   want.target_jack, want.action, want.was_level, want.last,
                   got.target_jack, got.action, got.was_level, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  leveling_board board;
  int cycle_count = 0;
  int phase_jacks [N_PHASES] = '{8, 3, 15, 1, 0, 6, 8};
  int phase_prec  [N_PHASES] = '{64, 0, 200, 10, 100, 32767, 500};

  jack_leveling_step_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // check before noting: a step taken on the edge of an older step's last word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_action(out_word);
      if (start && !busy) board.take_command(in_word);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic in_word_t make_word(logic [1:0] cmd, int jack, int slot, int nb,
                                         logic [1:0] code, bit valid, int x, int y);
    in_word_t w;
    w            = '0;
    w.cmd        = cmd;
    w.jack       = 3'(jack);
    w.slot       = 2'(slot);
    w.neighbor   = 3'(nb);
    w.axis_code  = code;
    w.link_valid = valid;
    w.x_angle    = 16'(x);
    w.y_angle    = 16'(y);
    return w;
  endfunction

  // tilt values clustered around the precision and level thresholds
  function automatic logic signed [15:0] pick_angle(int p);
    int v;
    int d;
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0: v = $signed(16'($urandom));
      1: v = p + d;
      2: v = -p + d;
      3: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      4: v = int'($urandom_range(0, 1200)) - 600;
      default: v = (5 * p) / 2 + d;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic idle_input(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(in_word_t w, bit allow_gap);
    if (allow_gap && $urandom_range(0, 2) == 0) idle_input($urandom_range(1, 3));
    @(negedge clk);
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // every expected word in, then let a trailing step finish
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (board.pending_actions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    int counted;
    int pick;
    int p;
    board     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset config, 8 jacks, precision 128
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // level at reset
    send_word(make_word(CMD_NOP, 5, 3, 7, CODE_Y11, 1, -1, -1), 1);      // dropped
    send_word(make_word(CMD_SAMPLE, 0, 0, 0, CODE_X0, 0, 320, 0), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // sum on threshold
    send_word(make_word(CMD_SAMPLE, 0, 0, 0, CODE_X0, 0, 321, 0), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // no links, empty
    send_word(make_word(CMD_WRITE, 1, 0, 0, CODE_X0, 1, 0, 0), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // lower jack 1
    send_word(make_word(CMD_WRITE, 2, 1, 0, CODE_X1, 1, 0, 0), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // raise jack 2
    send_word(make_word(CMD_SAMPLE, 3, 0, 0, CODE_X0, 0, 128, 128), 1);  // equal to precision
    send_word(make_word(CMD_WRITE, 4, 2, 3, CODE_X0, 1, 0, 0), 1);
    send_word(make_word(CMD_WRITE, 5, 3, 3, CODE_Y10, 1, 0, 0), 1);
    send_word(make_word(CMD_WRITE, 6, 0, 7, CODE_Y11, 1, 0, 0), 1);
    send_word(make_word(CMD_SAMPLE, 7, 0, 0, CODE_X0, 0, -32768, 32767), 1);
    send_word(make_word(CMD_WRITE, 7, 3, 6, CODE_Y10, 1, 0, 0), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);
    send_word(make_word(CMD_WRITE, 1, 0, 0, CODE_X0, 0, 0, 0), 1);       // clear a link
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);        // several raises
    send_word(make_word(CMD_SAMPLE, 0, 0, 0, CODE_X0, 0, 32767, -32768), 1);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);

    settle();
    cfg_write(CFG_JACK_COUNT, 16'h0000);                                  // no jack scanned
    cfg_write(CFG_SPARE, 16'($urandom));
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);
    settle();
    cfg_write(CFG_JACK_COUNT, {12'hfff, 4'd15});                          // clamps to 8
    cfg_write(CFG_PRECISION, {1'b1, 15'd0});
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);
    settle();
    cfg_write(CFG_JACK_COUNT, 16'd1);
    cfg_write(CFG_PRECISION, 16'd32767);
    send_word(make_word(CMD_STEP, 0, 0, 0, CODE_X0, 0, 0, 0), 1);

    // random phases, one config setting each; no idling in the final phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      cfg_write(CFG_JACK_COUNT, {12'($urandom), 4'(phase_jacks[ph])});
      cfg_write(CFG_PRECISION, {1'($urandom), 15'(phase_prec[ph])});
      p       = phase_prec[ph];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        w    = 45'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          w.cmd        = CMD_WRITE;
          w.link_valid = ($urandom_range(0, 4) != 0);
        end else if (pick < 76) begin
          w.cmd     = CMD_SAMPLE;
          w.x_angle = pick_angle(p);
          w.y_angle = pick_angle(p);
        end else if (pick < 96) begin
          w.cmd = CMD_STEP;
        end else begin
          w.cmd = CMD_NOP;
        end
        send_word(w, ph != N_PHASES - 1);
        if (w.cmd != CMD_NOP) counted++;
      end
    end

    settle();
    if (board.errors == 0 && board.pending_actions.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
